### design/iaf_pkg.sv
// Package for the integer-to-ASCII formatter: command codes, controller
// state and prefix types, and the character lookup and BCD correction functions.
// No dependencies.
`default_nettype none

package iaf_pkg;

    // Request command codes
    localparam logic [2:0] CMD_SDEC  = 3'd0;
    localparam logic [2:0] CMD_UDEC  = 3'd1;
    localparam logic [2:0] CMD_HEXL  = 3'd2;
    localparam logic [2:0] CMD_HEXU  = 3'd3;
    localparam logic [2:0] CMD_PTR   = 3'd4;
    localparam logic [2:0] CMD_CHAR  = 3'd5;
    localparam logic [2:0] CMD_PCT   = 3'd6;

    // Decimal conversion geometry: 32 source bits into 10 BCD digits
    localparam int DEC_BITS   = 32;
    localparam int DEC_DIGITS = 10;

    // Characters used by the prefixes
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_L       = 8'h6C;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } state_t;

    // Fixed text sent ahead of (or instead of) the digits
    typedef enum logic [2:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_HEX,
        PFX_NIL,
        PFX_CHAR,
        PFX_PCT
    } pfx_t;

    function automatic logic [2:0] prefix_len(input pfx_t kind);
        logic [2:0] len;
        case (kind)
            PFX_HEX: len = 3'd2;
            PFX_NIL: len = 3'd5;
            default: len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] prefix_char(input pfx_t kind, input logic [2:0] idx,
                                               input logic [7:0] chr);
        logic [7:0] c;
        case (kind)
            PFX_MINUS: c = CH_MINUS;
            PFX_HEX:   c = (idx == 3'd0) ? CH_ZERO : CH_X;
            PFX_NIL:
            begin
                case (idx)
                    3'd0:    c = CH_LPAREN;
                    3'd1:    c = CH_N;
                    3'd2:    c = CH_I;
                    3'd3:    c = CH_L;
                    default: c = CH_RPAREN;
                endcase
            end
            PFX_CHAR:  c = chr;
            PFX_PCT:   c = CH_PERCENT;
            default:   c = CH_ZERO;
        endcase
        return c;
    endfunction

    // One hex or BCD digit to ASCII
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {4'd0, d};
        end
        else
        begin
            c = (upper ? CH_UPPER_A : CH_LOWER_A) + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

    // Double-dabble correction: add 3 to every BCD digit of 5 or more
    function automatic logic [4*DEC_DIGITS-1:0] bcd_adjust(
        input logic [4*DEC_DIGITS-1:0] bcd);
        logic [4*DEC_DIGITS-1:0] r;
        r = bcd;
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (bcd[4*i +: 4] >= 4'd5)
            begin
                r[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/integer_to_ascii_formatter.sv
// Integer-to-ASCII formatter top level: request decode, bit-serial decimal
// conversion, leading-zero skip and one-character-per-cycle output.
// Depends on iaf_pkg.
//
// A request is taken when start is high and busy is low; busy then stays high
// until the last character has been issued. Characters appear one per cycle on
// out_char with out_valid within the prefix and within the digits, none during
// conversion or the skip step, most significant first, last marking the final
// one; the receiver cannot stall them. A request passes through its prefix
// characters (0 to 5), then for decimal the shift-and-add-3 conversion of the
// 32 source bits through a 10-digit BCD shift register, then the skip step that
// drops suppressed leading zeros, then the digits.
// Command code 7 is taken and produces nothing.
`default_nettype none

module integer_to_ascii_formatter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [2:0]  cmd,
    input  wire logic [63:0] value,
    output      logic        out_valid,
    output      logic [7:0]  out_char,
    output      logic        last
);
    import iaf_pkg::*;

    localparam int BCD_W  = 4 * DEC_DIGITS;
    localparam int BCD_LO = 64 - BCD_W;

    state_t       state_reg, state_next;
    logic         out_valid_reg, out_valid_next;
    logic [7:0]   out_char_reg, out_char_next;
    logic         last_reg, last_next;
    pfx_t         pfx_reg, pfx_next;
    logic [2:0]   pre_idx_reg, pre_idx_next;
    logic         dec_reg, dec_next;
    logic         has_num_reg, has_num_next;
    logic         upper_reg, upper_next;
    logic [7:0]   chr_reg, chr_next;
    logic [63:0]  digits_reg, digits_next;
    logic [31:0]  bin_reg, bin_next;
    logic [4:0]   cnt_reg, cnt_next;
    logic [4:0]   conv_cnt_reg, conv_cnt_next;
    logic [BCD_W-1:0] bcd_adj;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        pfx_reg      <= pfx_next;
        pre_idx_reg  <= pre_idx_next;
        dec_reg      <= dec_next;
        has_num_reg  <= has_num_next;
        upper_reg    <= upper_next;
        chr_reg      <= chr_next;
        digits_reg   <= digits_next;
        bin_reg      <= bin_next;
        cnt_reg      <= cnt_next;
        conv_cnt_reg <= conv_cnt_next;
    end

    assign bcd_adj = bcd_adjust(digits_reg[63:BCD_LO]);

    // Next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = 1'b0;
        out_char_next  = out_char_reg;
        last_next      = 1'b0;
        pfx_next       = pfx_reg;
        pre_idx_next   = pre_idx_reg;
        dec_next       = dec_reg;
        has_num_next   = has_num_reg;
        upper_next     = upper_reg;
        chr_next       = chr_reg;
        digits_next    = digits_reg;
        bin_next       = bin_reg;
        cnt_next       = cnt_reg;
        conv_cnt_next  = conv_cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    pfx_next      = PFX_NONE;
                    pre_idx_next  = 3'd0;
                    dec_next      = 1'b0;
                    has_num_next  = 1'b0;
                    upper_next    = 1'b0;
                    chr_next      = value[7:0];
                    digits_next   = '0;
                    bin_next      = value[31:0];
                    cnt_next      = 5'd8;
                    conv_cnt_next = 5'd0;
                    case (cmd)
                        CMD_SDEC:
                        begin
                            dec_next     = 1'b1;
                            has_num_next = 1'b1;
                            cnt_next     = 5'(DEC_DIGITS);
                            if (value[31])
                            begin
                                pfx_next = PFX_MINUS;
                                bin_next = 32'd0 - value[31:0];
                            end
                        end
                        CMD_UDEC:
                        begin
                            dec_next     = 1'b1;
                            has_num_next = 1'b1;
                            cnt_next     = 5'(DEC_DIGITS);
                        end
                        CMD_HEXL, CMD_HEXU:
                        begin
                            has_num_next = 1'b1;
                            upper_next   = (cmd == CMD_HEXU);
                            digits_next  = {value[31:0], 32'd0};
                        end
                        CMD_PTR:
                        begin
                            if (value == 64'd0)
                            begin
                                pfx_next = PFX_NIL;
                            end
                            else
                            begin
                                pfx_next     = PFX_HEX;
                                has_num_next = 1'b1;
                                digits_next  = value;
                                cnt_next     = 5'd16;
                            end
                        end
                        CMD_CHAR: pfx_next = PFX_CHAR;
                        CMD_PCT:  pfx_next = PFX_PCT;
                        default:  pfx_next = PFX_NONE;
                    endcase
                    if (pfx_next != PFX_NONE)
                        state_next = ST_PREFIX;
                    else if (dec_next)
                        state_next = ST_CONVERT;
                    else if (has_num_next)
                        state_next = ST_SKIP;
                end
            end

            // Fixed text, one character per cycle
            ST_PREFIX:
            begin
                out_valid_next = 1'b1;
                out_char_next  = prefix_char(pfx_reg, pre_idx_reg, chr_reg);
                if (pre_idx_reg == prefix_len(pfx_reg) - 3'd1)
                begin
                    last_next = !has_num_reg;
                    if (dec_reg)
                        state_next = ST_CONVERT;
                    else if (has_num_reg)
                        state_next = ST_SKIP;
                    else
                        state_next = ST_IDLE;
                end
                else
                begin
                    pre_idx_next = pre_idx_reg + 3'd1;
                end
            end

            // Double dabble, one source bit per cycle
            ST_CONVERT:
            begin
                digits_next[63:BCD_LO] = {bcd_adj[BCD_W-2:0], bin_reg[31]};
                bin_next      = {bin_reg[30:0], 1'b0};
                conv_cnt_next = conv_cnt_reg + 5'd1;
                if (conv_cnt_reg == 5'(DEC_BITS - 1))
                    state_next = ST_SKIP;
            end

            // Drop leading zeros, keeping at least one digit
            ST_SKIP:
            begin
                if (digits_reg[63:60] == 4'd0 && cnt_reg > 5'd1)
                begin
                    digits_next = {digits_reg[59:0], 4'd0};
                    cnt_next    = cnt_reg - 5'd1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                out_valid_next = 1'b1;
                out_char_next  = digit_char(digits_reg[63:60], upper_reg);
                digits_next    = {digits_reg[59:0], 4'd0};
                cnt_next       = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

### design/iaf_checker.sv
// Port-level checker for the integer-to-ASCII formatter, bound to the top level.
// Depends on iaf_pkg.
`default_nettype none

module iaf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [2:0]  cmd,
    input wire logic        out_valid,
    input wire logic [7:0]  out_char,
    input wire logic        last
);
    import iaf_pkg::*;

    // A character request produces exactly one, final, character
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd == CMD_CHAR |-> ##2 (out_valid && last))
        else $error("char request did not give a single last character");

    // A percent request prints the percent sign
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd == CMD_PCT |-> ##2 (out_valid && last && out_char == CH_PERCENT))
        else $error("percent request did not print percent sign");

    // Going idle coincides with the last character of the request
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (out_valid && last))
        else $error("busy dropped without a last character");

    // After the last character the block is ready for the next request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> !busy)
        else $error("still busy after last character");

endmodule

bind integer_to_ascii_formatter iaf_checker u_iaf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_char  (out_char),
    .last      (last)
);

`default_nettype wire

### bench/integer_to_ascii_formatter_tb.sv
// Testbench for integer_to_ascii_formatter: directed and random conversion requests,
// each checked character by character against a behavioral text predictor.
// Depends on iaf_pkg and the formatter RTL.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;

    import iaf_pkg::*;

    // Command code with no conversion behind it
    localparam logic [2:0] CMD_RSVD = 3'd7;

    localparam int RANDOM_REQUESTS = 180;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int MAX_GAP         = 48;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_exp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  cmd = 3'd0;
    logic [63:0] value = 64'd0;
    logic        busy;
    logic        out_valid;
    logic [7:0]  out_char;
    logic        last;

    char_exp_t   expected_chars[$];
    logic [7:0]  text_buf[$];
    int          mismatch_count = 0;
    int          stall_cycles = 0;
    bit          gaps_on = 1'b1;

    integer_to_ascii_formatter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .value     (value),
        .out_valid (out_valid),
        .out_char  (out_char),
        .last      (last)
    );

    always #6 clk = ~clk;

    // Text prediction
    // Digits of n in the given radix, most significant first, no leading zeros
    function automatic void append_digits(input logic [63:0] n, input int unsigned radix,
                                          input bit upper);
        logic [63:0] rest;
        logic [3:0]  d;
        logic [7:0]  rev[$];
        rest = n;
        if (rest == 64'd0)
        begin
            rev.push_back(8'h30);
        end
        while (rest != 64'd0)
        begin
            d = 4'(rest % radix);
            if (d < 4'd10)
            begin
                rev.push_back(8'h30 + 8'(d));
            end
            else
            begin
                rev.push_back((upper ? 8'h41 : 8'h61) + 8'(d) - 8'd10);
            end
            rest = rest / radix;
        end
        while (rev.size() > 0)
        begin
            text_buf.push_back(rev.pop_back());
        end
    endfunction

    // Expected characters of one request, queued in output order
    function automatic void predict_text(input logic [2:0] op_cmd, input logic [63:0] operand);
        logic [31:0] lo;
        string       nil_txt;
        char_exp_t   e;
        nil_txt = "(nil)";
        text_buf.delete();
        lo = operand[31:0];
        case (op_cmd)
            CMD_SDEC:
            begin
                if (lo[31])
                begin
                    text_buf.push_back(8'h2D);
                    lo = -lo;   // most negative value stays 0x80000000 = 2147483648
                end
                append_digits({32'd0, lo}, 10, 1'b0);
            end
            CMD_UDEC: append_digits({32'd0, lo}, 10, 1'b0);
            CMD_HEXL: append_digits({32'd0, lo}, 16, 1'b0);
            CMD_HEXU: append_digits({32'd0, lo}, 16, 1'b1);
            CMD_PTR:
            begin
                if (operand == 64'd0)
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        text_buf.push_back(nil_txt[i]);
                    end
                end
                else
                begin
                    text_buf.push_back(8'h30);
                    text_buf.push_back(8'h78);
                    append_digits(operand, 16, 1'b0);
                end
            end
            CMD_CHAR: text_buf.push_back(operand[7:0]);
            CMD_PCT:  text_buf.push_back(8'h25);
            default:  ;
        endcase
        for (int k = 0; k < text_buf.size(); k++)
        begin
            e.ch = text_buf[k];
            e.last = (k == text_buf.size() - 1);
            expected_chars.push_back(e);
        end
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endfunction

    // Result check: every strobed character against the oldest expectation
    always @(posedge clk)
    begin : char_check
        char_exp_t want;
        if (rst_n && out_valid)
        begin
            if (expected_chars.size() == 0)
            begin
                note_failure($sformatf("unexpected char 0x%02h last=%0b", out_char, last));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (want.ch !== out_char || want.last !== last)
                begin
                    note_failure($sformatf("expected char 0x%02h last=%0b, got 0x%02h last=%0b",
                                           want.ch, want.last, out_char, last));
                end
            end
        end
    end

    // Watchdog: cycles with neither a request transfer nor a character
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || out_valid)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // One request transfer; start stays high afterwards for back-to-back requests
    task automatic issue_request(input logic [2:0] op_cmd, input logic [63:0] operand);
        if (gaps_on && $urandom_range(0, 99) < 7)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= op_cmd;
        value <= operand;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        predict_text(op_cmd, operand);
    endtask

    // Random operand with varied magnitude so leading-zero counts spread out
    function automatic logic [63:0] random_operand();
        logic [63:0] r;
        logic [63:0] p;
        int unsigned k;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return r;
            1: return r >> $urandom_range(0, 63);
            2: return {r[63:32], 32'd0} | 64'($urandom_range(0, 99));
            3: return 64'd1 << $urandom_range(0, 63);
            4:
            begin
                // power of ten or one below it, upper half random
                p = 64'd1;
                k = $urandom_range(0, 9);
                repeat (k) p = p * 10;
                if ($urandom_range(0, 1))
                begin
                    p = p - 1;
                end
                return {r[63:32], p[31:0]};
            end
            default: return $urandom_range(0, 1) ? 64'd0 : ~64'd0;
        endcase
    endfunction

    task automatic test_signed_decimal();
        issue_request(CMD_SDEC, 64'd0);
        issue_request(CMD_SDEC, 64'd1);
        issue_request(CMD_SDEC, 64'hFFFF_FFFF);
        issue_request(CMD_SDEC, 64'h0000_0000_7FFF_FFFF);
        issue_request(CMD_SDEC, 64'h5A5A_5A5A_8000_0000);    // most negative value
    endtask

    task automatic test_unsigned_decimal();
        issue_request(CMD_UDEC, 64'hFFFF_FFFF_0000_0000);
        issue_request(CMD_UDEC, 64'h0000_0000_FFFF_FFFF);
        issue_request(CMD_UDEC, 64'd1000000000);
    endtask

    task automatic test_hex_digits();
        issue_request(CMD_HEXL, 64'd0);
        issue_request(CMD_HEXL, 64'h0000_0000_DEAD_BEEF);
        issue_request(CMD_HEXU, 64'h0000_0000_ABCD_EF01);
        issue_request(CMD_HEXU, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_pointer();
        issue_request(CMD_PTR, 64'd0);                       // null pointer
        issue_request(CMD_PTR, 64'd1);
        issue_request(CMD_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
        issue_request(CMD_PTR, 64'h8000_0000_0000_0000);
        issue_request(CMD_PTR, 64'h0000_0001_0000_0000);     // low half zero, not null
    endtask

    task automatic test_char_and_percent();
        issue_request(CMD_CHAR, 64'h00);
        issue_request(CMD_CHAR, 64'hFF);
        issue_request(CMD_CHAR, 64'hFFFF_FFFF_FFFF_FF41);
        issue_request(CMD_PCT, {$urandom, $urandom});
    endtask

    task automatic test_unused_command();
        issue_request(CMD_RSVD, 64'd12345);
        issue_request(CMD_RSVD, ~64'd0);
    endtask

    task automatic test_random_requests();
        int          n_sent;
        logic [2:0]  c;
        n_sent = 0;
        while (n_sent < RANDOM_REQUESTS)
        begin
            // middle stretch runs without gaps
            gaps_on = (n_sent < 80 || n_sent >= 140);
            c = ($urandom_range(0, 15) == 0) ? CMD_RSVD : 3'($urandom_range(0, 6));
            issue_request(c, random_operand());
            if (c != CMD_RSVD)
            begin
                n_sent++;
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_signed_decimal();
        test_unsigned_decimal();
        test_hex_digits();
        test_pointer();
        test_char_and_percent();
        test_unused_command();
        test_random_requests();

        // drain outstanding characters, then watch for strays
        start <= 1'b0;
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
design/iaf_pkg.sv
design/integer_to_ascii_formatter.sv
design/iaf_checker.sv
bench/integer_to_ascii_formatter_tb.sv
